// ===== hdl/tcs_pkg.sv =====
// Shared types and constants for the text console block
`default_nettype none
package tcs_pkg;
    localparam logic [2:0] KIND_RAW    = 3'd0;
    localparam logic [2:0] KIND_FMT    = 3'd1;
    localparam logic [2:0] KIND_UP     = 3'd2;
    localparam logic [2:0] KIND_DOWN   = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;
    localparam logic [2:0] KIND_COLOR  = 3'd5;
    localparam logic [2:0] KIND_PUT    = 3'd6;
    localparam logic [2:0] KIND_READ   = 3'd7;

    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] DEFAULT_COLOR = 8'h0F;

    typedef struct packed {
        logic       start;
        logic       scr_wr;
        logic       do_scroll_copy;
        logic       do_blank;
        logic       do_clear;
        logic       do_read;
    } tcs_cmd_t;

    typedef struct packed {
        logic       row_done;
        logic       screen_done;
        logic       read_done;
    } tcs_stat_t;
endpackage
`default_nettype wire

// ===== hdl/tcs_datapath.sv =====
// Screen and history memories with row copy, blank and read sweeps
`default_nettype none
module tcs_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int HISTORY = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tcs_pkg::tcs_cmd_t   cmd,
    input  wire logic [$clog2(ROWS)-1:0]    wr_prow,
    input  wire logic [$clog2(COLUMNS)-1:0] wr_col,
    input  wire logic [15:0]         wr_cell,
    input  wire logic [$clog2(ROWS)-1:0]    src_prow,
    input  wire logic [7:0]          hist_slot,
    input  wire logic                rd_hist,
    input  wire logic [7:0]          attr,
    output tcs_pkg::tcs_stat_t       stat,
    output logic [15:0]              rd_data
);
    import tcs_pkg::*;

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int SD = ROWS * COLUMNS;
    localparam int SW = $clog2(SD);
    localparam int HD = HISTORY * COLUMNS;
    localparam int HW = (HD > 1) ? $clog2(HD) : 1;

    logic [15:0] scr_mem [SD];
    logic [15:0] hist_mem [HD];

    logic [CW-1:0] x_reg, x_next;
    logic [RW-1:0] y_reg, y_next;
    logic [1:0]    ph_reg, ph_next;
    logic [15:0]   sd_reg;
    logic [15:0]   hd_reg;

    logic [SW-1:0] scr_addr;
    logic [HW-1:0] hist_addr;
    logic [RW-1:0] prow;
    logic          scr_we, hist_we, sweep;
    logic [15:0]   scr_wd;

    always_comb
    begin
        prow      = src_prow;
        if (cmd.do_clear)
            prow = y_reg;
        scr_addr  = SW'(prow * COLUMNS + x_reg);
        hist_addr = HW'(hist_slot * COLUMNS + x_reg);
        scr_we    = 1'b0;
        hist_we   = 1'b0;
        scr_wd    = {attr, CH_SPACE};
        sweep     = 1'b0;
        x_next    = x_reg;
        y_next    = y_reg;
        ph_next   = ph_reg;
        stat      = '0;
        if (cmd.start)
        begin
            x_next  = '0;
            y_next  = '0;
            ph_next = '0;
        end
        else if (cmd.scr_wr)
        begin
            scr_addr = SW'(wr_prow * COLUMNS + wr_col);
            scr_wd   = wr_cell;
            scr_we   = 1'b1;
        end
        else if (cmd.do_scroll_copy)
        begin
            // phase 0 reads screen, phase 1 writes history and blanks
            if (ph_reg == 2'd0)
                ph_next = 2'd1;
            else
            begin
                hist_we = 1'b1;
                scr_we  = 1'b1;
                ph_next = 2'd0;
                sweep   = 1'b1;
            end
        end
        else if (cmd.do_blank || cmd.do_clear)
        begin
            scr_we = 1'b1;
            sweep  = 1'b1;
        end
        else if (cmd.do_read)
        begin
            scr_addr  = SW'(prow * COLUMNS + wr_col);
            hist_addr = HW'(hist_slot * COLUMNS + wr_col);
            if (ph_reg == 2'd0)
                ph_next = 2'd1;
            else
                stat.read_done = 1'b1;
        end
        if (sweep)
        begin
            if (x_reg == CW'(COLUMNS - 1))
            begin
                x_next = '0;
                stat.row_done = 1'b1;
                if (y_reg == RW'(ROWS - 1))
                    stat.screen_done = 1'b1;
                else
                    y_next = y_reg + 1'b1;
            end
            else
                x_next = x_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg  <= '0;
            y_reg  <= '0;
            ph_reg <= '0;
        end
        else
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            ph_reg <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            scr_mem[scr_addr] <= scr_wd;
        sd_reg <= scr_mem[scr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_addr] <= sd_reg;
        hd_reg <= hist_mem[hist_addr];
    end

    assign rd_data = rd_hist ? hd_reg : sd_reg;
endmodule
`default_nettype wire

// ===== hdl/tcs_control.sv =====
// Command decode, cursor and history bookkeeping state machine
`default_nettype none
module tcs_control #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int HISTORY = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  kind,
    input  wire logic [7:0]  char_code,
    input  wire logic [7:0]  color,
    input  wire logic [6:0]  col,
    input  wire logic [4:0]  row,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      cell_res,
    output logic [6:0]       cursor_col,
    output logic [4:0]       cursor_row,
    output logic [10:0]      cursor_position,
    output logic [8:0]       view_offset,
    output logic [8:0]       lines_saved,
    output logic             at_bottom,
    output tcs_pkg::tcs_cmd_t cmd,
    input  wire tcs_pkg::tcs_stat_t stat,
    output logic [$clog2(ROWS)-1:0]    wr_prow,
    output logic [$clog2(COLUMNS)-1:0] wr_col,
    output logic [15:0]      wr_cell,
    output logic [$clog2(ROWS)-1:0]    src_prow,
    output logic [7:0]       hist_slot,
    output logic             rd_hist,
    output logic [7:0]       attr,
    input  wire logic [15:0] rd_data
);
    import tcs_pkg::*;

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_SCROLL = 7'b0001000,
        S_CLEAR  = 7'b0010000,
        S_READ   = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic [RW-1:0] top_reg, top_next;
    logic [7:0]    head_reg, head_next;
    logic [8:0]    cnt_reg, cnt_next;
    logic [8:0]    back_reg, back_next;
    logic [CW-1:0] cc_reg, cc_next;
    logic [RW-1:0] cr_reg, cr_next;
    logic [7:0]    tc_reg, tc_next;
    logic          dp_reg, dp_next;
    logic [15:0]   cell_reg, cell_next;
    logic [2:0]    k_reg;
    logic [7:0]    ch_reg, co_reg;
    logic [6:0]    x_reg;
    logic [4:0]    y_reg;
    logic [1:0]    np_reg, np_next;
    logic [7:0]    pc0_reg, pc0_next, pc1_reg, pc1_next;
    logic          fin_reg, fin_next;
    logic          rh_reg, rh_next;

    logic [CW:0]   cc_inc;
    logic [RW:0]   cr_inc;
    logic [RW:0]   top_sum, vis_sum;
    logic [9:0]    line;
    logic [9:0]    hline;
    logic [8:0]    hsum;
    logic          hexok;
    logic [3:0]    hexv;
    logic [7:0]    pch;

    always_comb
    begin
        hexok = 1'b0;
        hexv  = '0;
        if (char_code inside {[8'h30:8'h39]})
        begin
            hexok = 1'b1;
            hexv  = 4'(char_code - 8'h30);
        end
        else if (char_code inside {[8'h61:8'h66]})
        begin
            hexok = 1'b1;
            hexv  = 4'(char_code - 8'h57);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        top_next = top_reg; head_next = head_reg; cnt_next = cnt_reg;
        back_next = back_reg; cc_next = cc_reg; cr_next = cr_reg;
        tc_next = tc_reg; dp_next = dp_reg; cell_next = cell_reg;
        np_next = np_reg; pc0_next = pc0_reg; pc1_next = pc1_reg;
        fin_next = fin_reg; rh_next = rh_reg;
        cmd = '0;
        pch = (np_reg == 2'd2) ? pc1_reg : pc0_reg;
        cc_inc = {1'b0, cc_reg} + 1'b1;
        cr_inc = {1'b0, cr_reg} + 1'b1;
        top_sum = {1'b0, top_reg} + {1'b0, cr_reg};
        if (top_sum >= (RW+1)'(ROWS))
            top_sum = top_sum - (RW+1)'(ROWS);
        wr_prow = top_sum[RW-1:0];
        wr_col  = cc_reg;
        wr_cell = {tc_reg, pch};
        src_prow = top_reg;
        hsum = {1'b0, head_reg} + cnt_reg;
        if (hsum >= 9'(HISTORY))
            hsum = hsum - 9'(HISTORY);
        if (cnt_reg == 9'(HISTORY))
            hist_slot = head_reg;
        else
            hist_slot = 8'(hsum);
        attr = tc_reg;
        line = {1'b0, cnt_reg} - {1'b0, back_reg} + 10'(y_reg);
        hline = '0;
        rd_hist = rh_reg;
        vis_sum = '0;
        in_ready = (state_reg == S_IDLE);
        case (state_reg)
            S_INIT:
            begin
                cmd.do_clear = 1'b1;
                if (stat.screen_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_EXEC;
                    cell_next  = '0;
                    np_next    = '0;
                    fin_next   = 1'b0;
                    case (kind)
                        KIND_RAW:
                        begin
                            np_next  = 2'd1;
                            pc0_next = char_code;
                        end
                        KIND_FMT:
                        begin
                            fin_next = last;
                            if (dp_reg && hexok)
                            begin
                                dp_next = 1'b0;
                                tc_next = {4'h0, hexv};
                            end
                            else if (dp_reg)
                            begin
                                dp_next  = 1'b0;
                                pc0_next = CH_DOLLAR;
                                pc1_next = char_code;
                                np_next  = 2'd1;
                                if (char_code != CH_DOLLAR || last)
                                    np_next = 2'd2;
                                else
                                    dp_next = 1'b1;
                            end
                            else if (char_code == CH_DOLLAR && !last)
                                dp_next = 1'b1;
                            else
                            begin
                                pc0_next = char_code;
                                np_next  = 2'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_EXEC:
            begin
                if (np_reg != 2'd0)
                begin
                    back_next = '0;
                    np_next   = np_reg - 1'b1;
                    if (np_reg == 2'd2)
                        pc1_next = pc0_reg;
                    if (np_reg == 2'd2)
                        pch = pc0_reg;
                    wr_cell = {tc_reg, pch};
                    if (pch == CH_NEWLINE)
                    begin
                        cc_next = '0;
                        if (cr_inc == (RW+1)'(ROWS))
                        begin
                            cmd.start = 1'b1;
                            state_next = S_SCROLL;
                        end
                        else
                            cr_next = cr_inc[RW-1:0];
                    end
                    else
                    begin
                        cmd.scr_wr = 1'b1;
                        if (cc_inc == (CW+1)'(COLUMNS))
                        begin
                            cc_next = '0;
                            if (cr_inc == (RW+1)'(ROWS))
                            begin
                                state_next = S_SCROLL;
                            end
                            else
                                cr_next = cr_inc[RW-1:0];
                        end
                        else
                            cc_next = cc_inc[CW-1:0];
                    end
                    // second char printed is the old pc1, swapped into pc0
                    if (np_reg == 2'd2)
                        pc0_next = pc1_reg;
                end
                else
                begin
                    state_next = S_OUT;
                    case (k_reg)
                        KIND_FMT:
                        begin
                            if (fin_reg)
                            begin
                                tc_next = DEFAULT_COLOR;
                                dp_next = 1'b0;
                            end
                        end
                        KIND_UP:
                            if (back_reg < cnt_reg)
                                back_next = back_reg + 1'b1;
                        KIND_DOWN:
                            if (back_reg != '0)
                                back_next = back_reg - 1'b1;
                        KIND_CLEAR:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_CLEAR;
                        end
                        KIND_COLOR:
                            tc_next = co_reg;
                        KIND_PUT:
                        begin
                            if (x_reg < 7'(COLUMNS) && y_reg < 5'(ROWS))
                            begin
                                back_next = '0;
                                vis_sum = {1'b0, top_reg} + (RW+1)'(y_reg);
                                if (vis_sum >= (RW+1)'(ROWS))
                                    vis_sum = vis_sum - (RW+1)'(ROWS);
                                wr_prow = vis_sum[RW-1:0];
                                wr_col  = x_reg[CW-1:0];
                                wr_cell = {co_reg, ch_reg};
                                cmd.scr_wr = 1'b1;
                            end
                        end
                        KIND_READ:
                        begin
                            if (x_reg < 7'(COLUMNS) && y_reg < 5'(ROWS))
                            begin
                                cmd.start  = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCROLL:
            begin
                cmd.do_scroll_copy = 1'b1;
                if (stat.row_done)
                begin
                    if (cnt_reg == 9'(HISTORY))
                    begin
                        if ({1'b0, head_reg} == 9'(HISTORY - 1))
                            head_next = '0;
                        else
                            head_next = head_reg + 1'b1;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                    top_next = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    cr_next  = RW'(ROWS - 1);
                    state_next = S_EXEC;
                end
            end
            S_CLEAR:
            begin
                cmd.do_clear = 1'b1;
                if (stat.screen_done)
                begin
                    top_next = '0; head_next = '0; cnt_next = '0; back_next = '0;
                    cc_next = '0; cr_next = '0; dp_next = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_READ:
            begin
                cmd.do_read = 1'b1;
                wr_col = x_reg[CW-1:0];
                if (line < 10'(cnt_reg))
                begin
                    rh_next = 1'b1;
                    hline = 10'(head_reg) + line;
                    if (hline >= 10'(HISTORY))
                        hline = hline - 10'(HISTORY);
                    hist_slot = hline[7:0];
                end
                else
                begin
                    rh_next = 1'b0;
                    vis_sum = {1'b0, top_reg} + (RW+1)'(line - 10'(cnt_reg));
                    if (vis_sum >= (RW+1)'(ROWS))
                        vis_sum = vis_sum - (RW+1)'(ROWS);
                    src_prow = vis_sum[RW-1:0];
                end
                if (stat.read_done)
                begin
                    cell_next  = rd_data;
                    state_next = S_OUT;
                end
            end
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            top_reg <= '0; head_reg <= '0; cnt_reg <= '0; back_reg <= '0;
            cc_reg <= '0; cr_reg <= '0; tc_reg <= DEFAULT_COLOR; dp_reg <= 1'b0;
            np_reg <= '0; fin_reg <= 1'b0; rh_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg <= top_next; head_reg <= head_next; cnt_reg <= cnt_next;
            back_reg <= back_next; cc_reg <= cc_next; cr_reg <= cr_next;
            tc_reg <= tc_next; dp_reg <= dp_next;
            np_reg <= np_next; fin_reg <= fin_next; rh_reg <= rh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        pc0_reg  <= pc0_next;
        pc1_reg  <= pc1_next;
        if (in_ready && in_valid)
        begin
            k_reg <= kind; ch_reg <= char_code; co_reg <= color;
            x_reg <= col; y_reg <= row;
        end
    end

    assign out_valid       = (state_reg == S_OUT);
    assign cell_res        = cell_reg;
    assign cursor_col      = 7'(cc_reg);
    assign cursor_row      = 5'(cr_reg);
    assign cursor_position = 11'(cr_reg * COLUMNS + cc_reg);
    assign view_offset     = back_reg;
    assign lines_saved     = cnt_reg;
    assign at_bottom       = (back_reg == '0);
endmodule
`default_nettype wire

// ===== hdl/text_console_with_scrollback.sv =====
// Top level of the text console with scrollback history
//   channel | signals                                   | direction
//   in      | in_valid/in_ready, kind..last             | to block
//   out     | out_valid/out_ready, cell_res..at_bottom  | from block
// A scroll copies one row into history, reading then writing each cell;
// a clear walks the whole screen one cell a cycle.
// After reset a blanking pass over the whole screen runs before the first
// transaction is taken. A stalled result holds the block until taken.
`default_nettype none
module text_console_with_scrollback #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int HISTORY = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  kind,
    input  wire logic [7:0]  char_code,
    input  wire logic [7:0]  color,
    input  wire logic [6:0]  col,
    input  wire logic [4:0]  row,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      cell_res,
    output logic [6:0]       cursor_col,
    output logic [4:0]       cursor_row,
    output logic [10:0]      cursor_position,
    output logic [8:0]       view_offset,
    output logic [8:0]       lines_saved,
    output logic             at_bottom
);
    import tcs_pkg::*;

    tcs_cmd_t  cmd;
    tcs_stat_t stat;
    logic [$clog2(ROWS)-1:0]    wr_prow, src_prow;
    logic [$clog2(COLUMNS)-1:0] wr_col;
    logic [15:0] wr_cell, rd_data;
    logic [7:0]  hist_slot, attr;
    logic        rd_hist;

    tcs_control #(.COLUMNS(COLUMNS), .ROWS(ROWS), .HISTORY(HISTORY)) u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .kind, .char_code, .color, .col, .row,
        .last, .out_valid, .out_ready, .cell_res, .cursor_col, .cursor_row,
        .cursor_position, .view_offset, .lines_saved, .at_bottom, .cmd, .stat,
        .wr_prow, .wr_col, .wr_cell, .src_prow, .hist_slot, .rd_hist, .attr,
        .rd_data
    );

    tcs_datapath #(.COLUMNS(COLUMNS), .ROWS(ROWS), .HISTORY(HISTORY)) u_dp (
        .clk, .rst_n, .cmd, .wr_prow, .wr_col, .wr_cell, .src_prow, .hist_slot,
        .rd_hist, .attr, .stat, .rd_data
    );
endmodule
`default_nettype wire

// ===== verif/tb_text_console_with_scrollback.sv =====
// Testbench for the text console with scrollback: directed and random command streams
`default_nettype none
module tb_text_console_with_scrollback;
    timeunit 1ns;
    timeprecision 1ps;
    import tcs_pkg::*;

    localparam int NCOL = 80;
    localparam int NROW = 25;
    localparam int NHIST = 256;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [15:0] cell_val;
        logic [6:0]  ccol;
        logic [4:0]  crow;
        logic [10:0] cpos;
        logic [8:0]  voff;
        logic [8:0]  saved;
        logic        bottom;
    } console_view_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  kind = KIND_RAW;
    logic [7:0]  char_code = '0;
    logic [7:0]  color = '0;
    logic [6:0]  col = '0;
    logic [4:0]  row = '0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] cell_res;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_position;
    logic [8:0]  view_offset;
    logic [8:0]  lines_saved;
    logic        at_bottom;

    text_console_with_scrollback dut (.*);

    always #5 clk = ~clk;

    logic [15:0] scr [NROW][NCOL];
    logic [15:0] hist [NHIST][NCOL];
    int unsigned top_row, hist_head, hist_count, back, ccol, crow;
    logic [7:0]  tcolor;
    bit          dollar;

    console_view_t expected_views[$];
    int errors = 0;
    int cycles = 0;
    int sent = 0;
    int checked = 0;
    bit stall_mode = 1'b1;

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned screen_line(int unsigned r);
        return (top_row + r) % NROW;
    endfunction

    function automatic void scroll_up();
        int unsigned slot;
        if (hist_count < NHIST)
        begin
            slot = (hist_head + hist_count) % NHIST;
            hist_count++;
        end
        else
        begin
            slot = hist_head;
            hist_head = (hist_head + 1) % NHIST;
        end
        for (int x = 0; x < NCOL; x++)
        begin
            hist[slot][x] = scr[screen_line(0)][x];
            scr[screen_line(0)][x] = {tcolor, CH_SPACE};
        end
        top_row = (top_row + 1) % NROW;
        crow = NROW - 1;
    endfunction

    function automatic void emit_char(logic [7:0] c);
        back = 0;
        if (c == CH_NEWLINE)
        begin
            ccol = 0;
            if (++crow == NROW) scroll_up();
            return;
        end
        scr[screen_line(crow)][ccol] = {tcolor, c};
        if (++ccol == NCOL)
        begin
            ccol = 0;
            if (++crow == NROW) scroll_up();
        end
    endfunction

    function automatic void fresh_fmt(logic [7:0] c, bit lst);
        if (c == CH_DOLLAR)
        begin
            if (lst) emit_char(CH_DOLLAR);
            else dollar = 1'b1;
        end
        else emit_char(c);
    endfunction

    function automatic void console_reset();
        for (int y = 0; y < NROW; y++)
            for (int x = 0; x < NCOL; x++)
                scr[y][x] = {DEFAULT_COLOR, CH_SPACE};
        top_row = 0; hist_head = 0; hist_count = 0; back = 0;
        ccol = 0; crow = 0; tcolor = DEFAULT_COLOR; dollar = 1'b0;
    endfunction

    function automatic console_view_t console_step(logic [2:0] k, logic [7:0] ch,
            logic [7:0] at, logic [6:0] x, logic [4:0] y, bit lst);
        console_view_t v;
        int unsigned ln;
        v.cell_val = '0;
        case (k)
            KIND_RAW: emit_char(ch);
            KIND_FMT:
            begin
                if (dollar)
                begin
                    dollar = 1'b0;
                    if (ch >= 8'h30 && ch <= 8'h39) tcolor = ch - 8'h30;
                    else if (ch >= 8'h61 && ch <= 8'h66) tcolor = ch - 8'h61 + 8'd10;
                    else
                    begin
                        emit_char(CH_DOLLAR);
                        fresh_fmt(ch, lst);
                    end
                end
                else fresh_fmt(ch, lst);
                if (lst)
                begin
                    tcolor = DEFAULT_COLOR;
                    dollar = 1'b0;
                end
            end
            KIND_UP: if (back < hist_count) back++;
            KIND_DOWN: if (back > 0) back--;
            KIND_CLEAR:
            begin
                for (int r = 0; r < NROW; r++)
                    for (int c = 0; c < NCOL; c++)
                        scr[r][c] = {tcolor, CH_SPACE};
                top_row = 0; hist_head = 0; hist_count = 0; back = 0;
                ccol = 0; crow = 0; dollar = 1'b0;
            end
            KIND_COLOR: tcolor = at;
            KIND_PUT:
            if (x < NCOL && y < NROW)
            begin
                back = 0;
                scr[screen_line(y)][x] = {at, ch};
            end
            default:
            if (x < NCOL && y < NROW)
            begin
                ln = hist_count - back + y;
                if (ln < hist_count) v.cell_val = hist[(hist_head + ln) % NHIST][x];
                else v.cell_val = scr[screen_line(ln - hist_count)][x];
            end
        endcase
        v.ccol = 7'(ccol);
        v.crow = 5'(crow);
        v.cpos = 11'(crow * NCOL + ccol);
        v.voff = 9'(back);
        v.saved = 9'(hist_count);
        v.bottom = (back == 0);
        return v;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %0d: %s got %0h want %0h", checked, what, got, want);
        errors++;
    endtask

    task automatic send(logic [2:0] k, logic [7:0] ch = 8'h41, logic [7:0] at = 8'h0,
            logic [6:0] x = 0, logic [4:0] y = 0, bit lst = 1'b0);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        kind <= k; char_code <= ch; color <= at; col <= x; row <= y; last <= lst;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_views.push_back(console_step(k, ch, at, x, y, lst));
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_views.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                console_view_t w;
                checked++;
                if (expected_views.size() == 0)
                    report("unexpected transaction", cell_res, 16'h0000);
                else
                begin
                    w = expected_views.pop_front();
                    if (cell_res != w.cell_val) report("cell_res", cell_res, w.cell_val);
                    if (cursor_col != w.ccol)
                        report("cursor_col", 16'(cursor_col), 16'(w.ccol));
                    if (cursor_row != w.crow)
                        report("cursor_row", 16'(cursor_row), 16'(w.crow));
                    if (cursor_position != w.cpos)
                        report("cursor_position", 16'(cursor_position), 16'(w.cpos));
                    if (view_offset != w.voff)
                        report("view_offset", 16'(view_offset), 16'(w.voff));
                    if (lines_saved != w.saved)
                        report("lines_saved", 16'(lines_saved), 16'(w.saved));
                    if (at_bottom != w.bottom)
                        report("at_bottom", 16'(at_bottom), 16'(w.bottom));
                end
            end
            out_ready <= stall_mode ? ($urandom_range(0, 9) < 7) : 1'b1;
        end
    end

    task automatic rand_pos(output logic [6:0] x, output logic [4:0] y);
        if ($urandom_range(0, 9) < 8)
        begin
            x = 7'($urandom_range(0, NCOL - 1));
            y = 5'($urandom_range(0, NROW - 1));
        end
        else
        begin
            x = 7'($urandom);
            y = 5'($urandom);
        end
    endtask

    task automatic test_directed();
        send(KIND_READ, 0, 0, 0, 0);
        send(KIND_READ, 0, 0, 127, 31);
        send(KIND_RAW, 8'h00);
        send(KIND_RAW, 8'hFF);
        send(KIND_RAW, CH_NEWLINE);
        send(KIND_COLOR, 0, 8'hF0);
        send(KIND_RAW, 8'h5A);
        send(KIND_FMT, CH_DOLLAR);
        send(KIND_FMT, 8'h61);
        send(KIND_FMT, 8'h42);
        send(KIND_FMT, CH_DOLLAR);
        send(KIND_FMT, 8'h7A);
        send(KIND_FMT, CH_DOLLAR, 0, 0, 0, 1'b1);
        send(KIND_PUT, 8'hAA, 8'h55, 79, 24);
        send(KIND_PUT, 8'hAA, 8'h55, 80, 3);
        send(KIND_PUT, 8'hAA, 8'h55, 3, 25);
        send(KIND_READ, 0, 0, 79, 24);
        send(KIND_UP);
        send(KIND_DOWN);
        send(KIND_FMT, CH_DOLLAR);
        send(KIND_CLEAR);
        send(KIND_FMT, 8'h39, 0, 0, 0, 1'b1);
        send(KIND_READ, 0, 0, 0, 0);
    endtask

    task automatic test_scrollback();
        logic [6:0] x;
        logic [4:0] y;
        for (int i = 0; i < 40; i++) send(KIND_RAW, CH_NEWLINE);
        for (int i = 0; i < 20; i++) send(KIND_UP);
        for (int i = 0; i < 8; i++)
        begin
            rand_pos(x, y);
            send(KIND_READ, 0, 0, x, y);
        end
        for (int i = 0; i < 25; i++) send(KIND_DOWN);
    endtask

    task automatic test_history_full();
        stall_mode = 1'b0;
        for (int i = 0; i < 250; i++) send(KIND_RAW, CH_NEWLINE);
        for (int i = 0; i < 260; i++) send(KIND_UP);
        send(KIND_READ, 0, 0, 0, 0);
        send(KIND_DOWN);
        stall_mode = 1'b1;
        drain();
    endtask

    task automatic test_random(int n);
        logic [6:0] x;
        logic [4:0] y;
        int p;
        for (int i = 0; i < n; i++)
        begin
            rand_pos(x, y);
            p = $urandom_range(0, 99);
            if (p < 25)
                send(KIND_RAW, ($urandom_range(0, 5) == 0) ? CH_NEWLINE : 8'($urandom));
            else if (p < 45)
            begin
                if ($urandom_range(0, 2) == 0) send(KIND_FMT, CH_DOLLAR);
                send(KIND_FMT,
                     ($urandom_range(0, 1) ? 8'($urandom_range(8'h30, 8'h66)) : 8'($urandom)),
                     0, 0, 0, $urandom_range(0, 3) == 0);
            end
            else if (p < 58) send(KIND_UP);
            else if (p < 66) send(KIND_DOWN);
            else if (p < 67) send(KIND_CLEAR);
            else if (p < 72) send(KIND_COLOR, 0, 8'($urandom));
            else if (p < 82) send(KIND_PUT, 8'($urandom), 8'($urandom), x, y);
            else send(KIND_READ, 0, 0, x, y);
            if (i == n / 2) drain();
        end
    endtask

    initial
    begin
        console_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_scrollback();
        test_history_full();
        test_random(130);
        drain();
        repeat (200) @(posedge clk);
        $display("ran %0d commands, %0d results checked", sent, checked);
        $display("covered text, formatted colour, scrollback, full history, put and read");
        if (errors == 0 && expected_views.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
